[hdl/tmx_pkg.sv]
`timescale 1ns / 1ps

package tmx_pkg;

  // controls for the serial running-max unit
  typedef struct packed {
    logic clear;
    logic step;
    logic cand_bit;
    logic commit;
  } best_ctrl_t;

endpackage

[hdl/tmx_ram.sv]
`timescale 1ns / 1ps

module tmx_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/tmx_best.sv]
`timescale 1ns / 1ps

module tmx_best #(
  parameter int WORD_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  tmx_pkg::best_ctrl_t    ctrl,
  output logic [WORD_BITS-1:0]   best_new
);

  logic [WORD_BITS-1:0] cand_sr;
  logic [WORD_BITS-1:0] best_sr;
  logic                 gt;
  logic                 lt;

  // best_sr rotates once per level, so it is back in place after a full walk
  always_ff @(posedge clk) begin
    if (rst) begin
      gt <= 1'b0;
      lt <= 1'b0;
    end else begin
      if (ctrl.clear) begin
        best_sr <= '0;
        gt      <= 1'b0;
        lt      <= 1'b0;
      end else if (ctrl.step) begin
        cand_sr <= {cand_sr[WORD_BITS-2:0], ctrl.cand_bit};
        best_sr <= {best_sr[WORD_BITS-2:0], best_sr[WORD_BITS-1]};
        if (!gt && !lt) begin
          if (ctrl.cand_bit && !best_sr[WORD_BITS-1]) begin
            gt <= 1'b1;
          end else if (!ctrl.cand_bit && best_sr[WORD_BITS-1]) begin
            lt <= 1'b1;
          end
        end
      end else if (ctrl.commit) begin
        best_sr <= best_new;
        gt      <= 1'b0;
        lt      <= 1'b0;
      end
    end
  end

  assign best_new = gt ? cand_sr : best_sr;

endmodule

[hdl/max_subarray_xor_trie.sv]
`timescale 1ns / 1ps

// Maximum subarray XOR over a stream of words, using a binary trie of prefix XORs kept in
// two child-link RAMs (one per branch bit). Each word updates the prefix, inserts it into
// the trie and then walks the trie preferring the opposite bit; one result beat follows
// each input beat. The block works on one word at a time: the next word is accepted only
// after the previous one has finished both walks and its result has been registered. The
// rate is set by the trie walks, one trie level per cycle through the child-link RAM read
// port, an insert walk followed by a full query walk. After reset and after a word marked
// last, a clearing pass resets the root and inserts the empty prefix; no word is accepted
// during it. If the pool lacks the nodes for a new path the insert is skipped and overflow
// stays set until the end of the sequence.
module max_subarray_xor_trie #(
  parameter int WORD_BITS = 32,
  parameter int NODE_POOL = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [WORD_BITS-1:0] word,
  input  logic                 last,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic [WORD_BITS-1:0] best_xor,
  output logic                 overflow,
  output logic                 out_valid,
  input  logic                 out_ready
);

  localparam int NW = $clog2(NODE_POOL);
  localparam int CW = NW + 1;
  localparam int LW = $clog2(WORD_BITS);
  localparam int SW = ((CW > LW) ? CW : LW) + 1;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_WALK   = 9'b000000010,
    S_CHECK  = 9'b000000100,
    S_ALLOC  = 9'b000001000,
    S_QSTART = 9'b000010000,
    S_QWALK  = 9'b000100000,
    S_FINISH = 9'b001000000,
    S_CLEAR  = 9'b010000000,
    S_ISTART = 9'b100000000
  } state_t;

  state_t               state;
  logic [WORD_BITS-1:0] prefix;
  logic [WORD_BITS-1:0] key_sr;
  logic [LW-1:0]        lvl;
  logic [NW-1:0]        node;
  logic [CW-1:0]        nodes_used;
  logic                 ovf;
  logic                 last_q;
  logic                 init;
  logic                 first;

  logic [NW-1:0]        rd0;
  logic [NW-1:0]        rd1;
  logic [NW-1:0]        raddr;
  logic [NW-1:0]        waddr;
  logic [NW-1:0]        wd0;
  logic [NW-1:0]        wd1;
  logic                 we0;
  logic                 we1;
  logic [NW-1:0]        fresh;
  logic                 kbit;
  logic [NW-1:0]        child;
  logic [NW-1:0]        opp;
  logic [NW-1:0]        qnext;
  logic                 pool_short;
  logic                 out_free;
  logic [WORD_BITS-1:0] best_new;
  state_t               done_state;
  tmx_pkg::best_ctrl_t  bctl;

  always_comb begin
    kbit       = key_sr[WORD_BITS-1];
    child      = kbit ? rd1 : rd0;
    opp        = kbit ? rd0 : rd1;
    // with no child at all the walk stays put, which only happens in an empty trie
    qnext      = (opp != '0) ? opp : ((child != '0) ? child : node);
    fresh      = nodes_used[NW-1:0];
    pool_short = (SW'(nodes_used) + SW'(lvl) + SW'(1)) > SW'(NODE_POOL);
    out_free   = !out_valid || out_ready;
    done_state = init ? S_IDLE : S_QSTART;
    in_ready   = (state == S_IDLE);

    unique case (state)
      S_WALK:  raddr = (child != '0) ? child : node;
      S_QWALK: raddr = qnext;
      default: raddr = '0;
    endcase

    we0   = 1'b0;
    we1   = 1'b0;
    waddr = node;
    wd0   = '0;
    wd1   = '0;
    if (state == S_CLEAR) begin
      we0   = 1'b1;
      we1   = 1'b1;
      waddr = '0;
    end else if (state == S_ALLOC) begin
      // a fresh node also gets its other link cleared; the node the walk ended on keeps it
      if (kbit) begin
        we1 = 1'b1;
        wd1 = fresh;
        we0 = !first;
      end else begin
        we0 = 1'b1;
        wd0 = fresh;
        we1 = !first;
      end
    end

    bctl.clear    = (state == S_CLEAR);
    bctl.step     = (state == S_QWALK);
    bctl.cand_bit = (opp != '0);
    bctl.commit   = (state == S_FINISH) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            key_sr <= prefix ^ word;
            prefix <= prefix ^ word;
            last_q <= last;
            lvl    <= LW'(WORD_BITS - 1);
            node   <= '0;
            state  <= S_WALK;
          end
        end
        S_WALK: begin
          if (child != '0) begin
            node   <= child;
            key_sr <= {key_sr[WORD_BITS-2:0], 1'b0};
            if (lvl == '0) begin
              init  <= 1'b0;
              state <= done_state;
            end else begin
              lvl <= lvl - LW'(1);
            end
          end else begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (pool_short) begin
            ovf   <= 1'b1;
            init  <= 1'b0;
            state <= done_state;
          end else begin
            first <= 1'b1;
            state <= S_ALLOC;
          end
        end
        S_ALLOC: begin
          node       <= fresh;
          nodes_used <= nodes_used + CW'(1);
          key_sr     <= {key_sr[WORD_BITS-2:0], 1'b0};
          first      <= 1'b0;
          if (lvl == '0) begin
            init  <= 1'b0;
            state <= done_state;
          end else begin
            lvl <= lvl - LW'(1);
          end
        end
        S_QSTART: begin
          key_sr <= prefix;
          lvl    <= LW'(WORD_BITS - 1);
          node   <= '0;
          state  <= S_QWALK;
        end
        S_QWALK: begin
          node   <= qnext;
          key_sr <= {key_sr[WORD_BITS-2:0], 1'b0};
          if (lvl == '0) begin
            state <= S_FINISH;
          end else begin
            lvl <= lvl - LW'(1);
          end
        end
        S_FINISH: begin
          if (out_free) begin
            best_xor  <= best_new;
            overflow  <= ovf;
            state     <= last_q ? S_CLEAR : S_IDLE;
          end
        end
        S_CLEAR: begin
          prefix     <= '0;
          ovf        <= 1'b0;
          nodes_used <= CW'(1);
          init       <= 1'b1;
          key_sr     <= '0;
          lvl        <= LW'(WORD_BITS - 1);
          node       <= '0;
          state      <= S_ISTART;
        end
        S_ISTART: begin
          // root links written last cycle, read them now
          state <= S_WALK;
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

  tmx_ram #(
    .WIDTH (NW),
    .DEPTH (NODE_POOL)
  ) u_link0 (
    .clk   (clk),
    .we    (we0),
    .waddr (waddr),
    .wdata (wd0),
    .raddr (raddr),
    .rdata (rd0)
  );

  tmx_ram #(
    .WIDTH (NW),
    .DEPTH (NODE_POOL)
  ) u_link1 (
    .clk   (clk),
    .we    (we1),
    .waddr (waddr),
    .wdata (wd1),
    .raddr (raddr),
    .rdata (rd1)
  );

  tmx_best #(
    .WORD_BITS (WORD_BITS)
  ) u_best (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (bctl),
    .best_new (best_new)
  );

endmodule

[hdl/tmx_checker.sv]
`timescale 1ns / 1ps

module tmx_checker #(
  parameter int WORD_BITS = 32
) (
  input logic                 clk,
  input logic                 rst,
  input logic [WORD_BITS-1:0] word,
  input logic                 last,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic [WORD_BITS-1:0] best_xor,
  input logic                 overflow,
  input logic                 out_valid,
  input logic                 out_ready
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(best_xor) && $stable(overflow))
    else $error("result beat changed while stalled");

  // a waiting input beat holds its payload
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(word) && $stable(last))
    else $error("input beat changed while waiting");

  // reset starts the clearing pass with nothing pending
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !in_ready)
    else $error("block not quiet after reset");

  // one word at a time: an accepted word closes the input until its work is done
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input reopened right after an accepted beat");

endmodule

bind max_subarray_xor_trie tmx_checker #(.WORD_BITS(WORD_BITS)) u_tmx_checker (
  .clk       (clk),
  .rst       (rst),
  .word      (word),
  .last      (last),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .best_xor  (best_xor),
  .overflow  (overflow),
  .out_valid (out_valid),
  .out_ready (out_ready)
);
